// ===== rtl/fnw_pkg.sv =====
`timescale 1ns / 1ps

package fnw_pkg;

   // Fixed field widths
   localparam int SAMPLE_W   = 32;
   localparam int WS_W       = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register map: index bit taken from paddr[2]
   localparam logic REG_WINDOW_SIZE = 1'b0;

   localparam logic [WS_W-1:0] WS_RESET = 7'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [WS_W-1:0]            window_size_type;

   // One result as it sits in the output stage
   typedef struct packed {
      sample_type first_negative;
      logic       found;
   } result_type;

endpackage

// ===== rtl/first_negative_in_window.sv =====
`timescale 1ns / 1ps
// Results are registered; throughput is one sample per cycle unless the
// skid slot is full. The queue memory's single read port prefetches the
// entry behind the head every cycle, so a pop never waits.
// Reset (synchronous, active high): window_size = 3, queue and window empty.
// Queue memory is not cleared; entries are only read after being written.
module first_negative_in_window
   import fnw_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // sample channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sample_type            req_sample,
   input  logic                  req_start_of_sequence,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sample_type            rsp_first_negative,
   output logic                  rsp_found,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW   = $clog2(MAX_WINDOW + 1);
   localparam int PW   = $clog2(2 * MAX_WINDOW);
   localparam int CMPW = ((PW > WS_W) ? PW : WS_W) + 1;
   localparam int EW   = PW + SAMPLE_W;

   localparam logic [AW-1:0]   HEAD_LAST = AW'(MAX_WINDOW - 1);
   localparam logic [PW-1:0]   POS_LAST  = PW'(2 * MAX_WINDOW - 1);
   localparam logic [CW-1:0]   COUNT_MAX = CW'(MAX_WINDOW);
   localparam logic [CMPW-1:0] POS_MOD   = CMPW'(2 * MAX_WINDOW);
   localparam logic [CMPW-1:0] WIN_MAX   = CMPW'(MAX_WINDOW);

   // queue entry: position over value
   typedef logic [EW-1:0] entry_type;

   // config register
   window_size_type window_size_ff, window_size_in;

   // queue control state
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [CW-1:0] fill_ff, fill_in;

   // head entry held in flops
   logic [PW-1:0] head_pos_ff, head_pos_in;
   sample_type    head_val_ff, head_val_in;

   // queue memory and its read path
   entry_type     queue_mem [MAX_WINDOW];
   entry_type     rd_data_ff;
   entry_type     byp_data_ff;
   logic          byp_hit_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic          wr_en;
   entry_type     next_entry;

   // output stage with skid
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   // item datapath
   logic            accept;
   logic            csr_write;
   logic [CW-1:0]   eff_window;
   logic [CMPW-1:0] ws_ext;
   logic [AW-1:0]   base_head, base_tail, head_pop;
   logic [CW-1:0]   base_count, count_pop;
   logic [PW-1:0]   base_pos;
   logic [CW-1:0]   base_fill, fill_new;
   logic [CMPW-1:0] age;
   logic            pop, push;
   logic [AW-1:0]   rd_head;
   result_type      res;
   logic            res_valid;
   logic            out_take;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == REG_WINDOW_SIZE);
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW_SIZE)
                       ? CSR_DATA_W'(window_size_ff) : '0;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   // effective window: 0 counts as 1, clamp to queue depth
   always_comb begin
      ws_ext = CMPW'(window_size_ff);
      if (ws_ext == '0) begin
         eff_window = CW'(1);
      end else if (ws_ext > WIN_MAX) begin
         eff_window = COUNT_MAX;
      end else begin
         eff_window = CW'(window_size_ff);
      end
   end

   // entry behind the head: memory data or a write that raced the read
   assign next_entry = byp_hit_ff ? byp_data_ff : rd_data_ff;

   // evict / push / fill for the item on the request port
   always_comb begin
      base_head  = req_start_of_sequence ? '0 : head_ff;
      base_tail  = req_start_of_sequence ? '0 : tail_ff;
      base_count = req_start_of_sequence ? '0 : count_ff;
      base_pos   = req_start_of_sequence ? '0 : pos_ff;
      base_fill  = req_start_of_sequence ? '0 : fill_ff;

      // age of head entry, modulo 2*MAX_WINDOW
      age = CMPW'(base_pos) - CMPW'(head_pos_ff)
            + ((base_pos < head_pos_ff) ? POS_MOD : '0);

      pop       = (base_count != '0) && (age >= CMPW'(eff_window));
      count_pop = base_count - CW'(pop);
      head_pop  = !pop ? base_head : ((base_head == HEAD_LAST) ? '0 : base_head + 1'b1);
      push      = req_sample[SAMPLE_W-1] && (count_pop < COUNT_MAX);

      wr_addr = base_tail;
      wr_data = {base_pos, req_sample};
      wr_en   = accept && push && !csr_write;

      fill_new  = (base_fill < eff_window) ? base_fill + 1'b1 : base_fill;
      res_valid = accept && !(fill_new < eff_window);
   end

   // state next values
   always_comb begin
      window_size_in = window_size_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      fill_in        = fill_ff;
      head_pos_in    = head_pos_ff;
      head_val_in    = head_val_ff;

      if (csr_write) begin
         window_size_in = csr_pwdata[WS_W-1:0];
         head_in        = '0;
         tail_in        = '0;
         count_in       = '0;
         pos_in         = '0;
         fill_in        = '0;
      end else if (accept) begin
         head_in  = head_pop;
         tail_in  = !push ? base_tail : ((base_tail == HEAD_LAST) ? '0 : base_tail + 1'b1);
         count_in = count_pop + CW'(push);
         pos_in   = (base_pos == POS_LAST) ? '0 : base_pos + 1'b1;
         fill_in  = fill_new;
         // new head: pushed entry into an empty queue, else prefetched one
         if (count_pop == '0 && push) begin
            head_pos_in = base_pos;
            head_val_in = req_sample;
         end else if (pop) begin
            head_pos_in = next_entry[EW-1:SAMPLE_W];
            head_val_in = next_entry[SAMPLE_W-1:0];
         end
      end
   end

   // prefetch the slot after the next head
   assign rd_head = head_in;
   assign rd_addr = (rd_head == HEAD_LAST) ? '0 : rd_head + 1'b1;

   // result for this transfer
   always_comb begin
      res.found          = (count_in != '0);
      res.first_negative = res.found ? head_val_in : '0;
   end

   // output register plus skid slot
   assign out_take = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_first_negative = out_ff.first_negative;
   assign rsp_found          = out_ff.found;

   // queue memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= queue_mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WS_RESET;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         pos_ff         <= '0;
         fill_ff        <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
         byp_hit_ff     <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         pos_ff         <= pos_in;
         fill_ff        <= fill_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
         byp_hit_ff     <= wr_en && (wr_addr == rd_addr);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_pos_ff <= head_pos_in;
      head_val_ff <= head_val_in;
      out_ff      <= out_in;
      skid_ff     <= skid_in;
   end

endmodule

// ===== tb/tb_first_negative_in_window.sv =====
`timescale 1ns / 1ps

module tb_first_negative_in_window
   import fnw_pkg::*;
();

   localparam int MAX_WIN        = 64;
   localparam int POS_MOD        = 2 * MAX_WIN;
   localparam int MAX_GAP        = 12;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TARGET    = 1650;

   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED      = {~REG_WINDOW_SIZE, 2'b00};

   localparam sample_type SAMPLE_MIN = 32'sh8000_0000;
   localparam sample_type SAMPLE_MAX = 32'sh7FFF_FFFF;

   // Tracks the window of negative samples and queues the results they imply
   class neg_window_tracker;
      window_size_type ws_reg;
      sample_type      neg_vals[MAX_WIN];
      int unsigned     neg_pos[MAX_WIN];
      int unsigned     head, tail, count, next_pos, fill;
      result_type      expected_results[$];
      int              errors;

      function new();
         ws_reg = WS_RESET;
         errors = 0;
         clear_window();
      endfunction

      function void clear_window();
         head     = 0;
         tail     = 0;
         count    = 0;
         next_pos = 0;
         fill     = 0;
      endfunction

      // window size as the block uses it: 0 acts as 1, above MAX_WIN clamps
      function int unsigned span();
         int unsigned k;
         k = ws_reg;
         if (k == 0) k = 1;
         if (k > MAX_WIN) k = MAX_WIN;
         return k;
      endfunction

      function void write_reg(logic idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_WINDOW_SIZE) begin
            ws_reg = data[WS_W-1:0];
            clear_window();
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_sample(sample_type s, logic sos);
         int unsigned k, pos, age;
         result_type  r;
         k = span();
         if (sos) clear_window();
         pos = next_pos % POS_MOD;

         // drop at most one stale entry at the head
         if (count > 0) begin
            age = (pos + POS_MOD - neg_pos[head]) % POS_MOD;
            if (age >= k) begin
               head = (head + 1) % MAX_WIN;
               count--;
            end
         end

         // negative samples join the tail
         if (s[SAMPLE_W-1] && count < MAX_WIN) begin
            neg_vals[tail] = s;
            neg_pos[tail]  = pos;
            tail = (tail + 1) % MAX_WIN;
            count++;
         end

         next_pos = (pos + 1) % POS_MOD;
         if (fill < k) fill++;
         if (fill < k) return;

         if (count > 0) begin
            r.first_negative = neg_vals[head];
            r.found          = 1'b1;
         end else begin
            r.first_negative = '0;
            r.found          = 1'b0;
         end
         expected_results = {expected_results, r};
      endfunction

      function void check_result(sample_type fn, logic fd);
         result_type r;
         if (expected_results.size() == 0) begin
            $error("unexpected result: first_negative=%0d found=%0b", fn, fd);
            errors++;
            return;
         end
         r = expected_results.pop_front();
         if (r.first_negative !== fn) begin
            $error("first_negative: expected %0d, got %0d", r.first_negative, fn);
            errors++;
         end
         if (r.found !== fd) begin
            $error("found: expected %0b, got %0b", r.found, fd);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sample_type            req_sample = '0;
   logic                  req_start_of_sequence = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   sample_type            rsp_first_negative;
   logic                  rsp_found;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   neg_window_tracker tracker;
   bit                no_idle = 1'b0;
   int                items_sent = 0;
   int                quiet_cycles = 0;

   first_negative_in_window #(.MAX_WINDOW(MAX_WIN)) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample            (req_sample),
      .req_start_of_sequence (req_start_of_sequence),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_first_negative    (rsp_first_negative),
      .rsp_found             (rsp_found),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Observe every transfer; inputs before results in case both land together
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            tracker.write_reg(csr_paddr[2], csr_pwdata);
         if (req_valid && req_ready)
            tracker.note_sample(req_sample, req_start_of_sequence);
         if (rsp_valid && rsp_ready)
            tracker.check_result(rsp_first_negative, rsp_found);
      end
   end

   // Watchdog: ends the run after too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Result side: random stall before each transfer
   initial begin
      int gap;
      @(negedge reset);
      @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   task automatic send_sample(input sample_type s, input logic sos);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_sample            <= s;
      req_start_of_sequence <= sos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Hold the sender until every expected result has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write the window size while idle, then read it back
   task automatic set_window(input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] rd;
      wait_drained();
      csr_write(ADDR_WINDOW_SIZE, data);
      csr_read(ADDR_WINDOW_SIZE, rd);
      if (rd[WS_W-1:0] !== data[WS_W-1:0]) begin
         $error("window_size readback: expected %0d, got %0d", data[WS_W-1:0],
                rd[WS_W-1:0]);
         tracker.errors++;
      end
   endtask

   function automatic sample_type pick_sample(int neg_pct);
      sample_type s;
      case ($urandom_range(0, 15))
         0: s = SAMPLE_MIN;
         1: s = SAMPLE_MAX;
         2: s = '0;
         3: s = -1;
         default: begin
            s = $urandom();
            s[SAMPLE_W-1] = ($urandom_range(0, 99) < neg_pct);
         end
      endcase
      return s;
   endfunction

   task automatic run_sequence(input int len, input int neg_pct, input logic lead_sos);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(neg_pct), (i == 0) ? lead_sos : 1'b0);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rd;
      window_size_type       ws;
      int                    k, phase, nseq, len, neg_pct;

      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the window size
      csr_read(ADDR_WINDOW_SIZE, rd);
      if (rd[WS_W-1:0] !== WS_RESET) begin
         $error("window_size after reset: expected %0d, got %0d", WS_RESET, rd[WS_W-1:0]);
         tracker.errors++;
      end

      // window of three: extremes, eviction down to an empty window
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample('0, 1'b0);
      send_sample(-1, 1'b0);
      send_sample(5, 1'b0);
      send_sample(7, 1'b0);
      send_sample(9, 1'b0);
      // a sequence shorter than the window, then a new sequence
      send_sample(-2, 1'b1);
      send_sample(-3, 1'b0);
      send_sample(-4, 1'b1);
      send_sample(1, 1'b0);
      send_sample(2, 1'b0);

      // unused register: no effect, the window carries on
      wait_drained();
      csr_write(ADDR_UNUSED, $urandom());
      send_sample(-6, 1'b0);
      send_sample(3, 1'b0);

      // zero window acts as one
      set_window('0);
      send_sample(-7, 1'b0);
      send_sample(3, 1'b0);
      send_sample(-9, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);

      // upper data bits are not part of the register
      set_window({{(CSR_DATA_W-WS_W){1'b1}}, 7'd2});
      send_sample(4, 1'b0);
      send_sample(-8, 1'b0);
      send_sample(-1, 1'b0);
      send_sample(6, 1'b0);

      // random phases, each with its own window setting
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: ws = 7'd64;
            1: ws = 7'd127;
            2: ws = 7'd1;
            3: ws = 7'd65;
            4: ws = 7'd0;
            default: begin
               case ($urandom_range(0, 9))
                  0:       ws = $urandom_range(65, 127);
                  1, 2:    ws = $urandom_range(9, 64);
                  default: ws = $urandom_range(1, 8);
               endcase
            end
         endcase
         set_window({$urandom_range(0, 1) ? $urandom() : 32'd0} & ~32'h7F | ws);
         if ($urandom_range(0, 3) == 0) begin
            wait_drained();
            csr_write(ADDR_UNUSED, $urandom());
         end

         k = (ws == 0) ? 1 : (ws > MAX_WIN) ? MAX_WIN : ws;
         no_idle = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 4))
            0: neg_pct = 0;
            1: neg_pct = 10;
            2: neg_pct = 50;
            3: neg_pct = 90;
            default: neg_pct = 100;
         endcase
         nseq = (k > 16) ? $urandom_range(1, 2) : $urandom_range(2, 5);

         for (int s = 0; s < nseq; s++) begin
            // mostly full sequences; some no longer than the window
            if ($urandom_range(0, 7) == 0)
               len = $urandom_range(1, k);
            else
               len = k + $urandom_range(0, (k > 16) ? 40 : 3 * k + 8);
            run_sequence(len, neg_pct, (s > 0) || $urandom_range(0, 1));
            if (phase == 1 || $urandom_range(0, 5) == 0)
               wait_drained();
         end
         phase++;
      end

      no_idle = 1'b0;
      wait_drained();
      repeat (4 * DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
